// File: src/l2lt_pkg.sv
// Package: shared types and constants for the L2 learning table.
`default_nettype none
package l2lt_pkg;
    localparam int MacW   = 48;
    localparam int SwW    = 64;
    localparam int PortW  = 32;
    localparam int StampW = 32;
    localparam int CfgW   = 16;

    localparam logic [CfgW-1:0] MaxAgeReset   = 16'd300;
    localparam logic [CfgW-1:0] AgingIntReset = 16'd5;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_FLOOD   = 2'd1,
        ACT_FORWARD = 2'd2
    } action_t;

    typedef enum logic {
        REG_MAX_AGE   = 1'b0,
        REG_AGING_INT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_PACKET = 1'b0,
        MODE_TICK   = 1'b1
    } mode_t;

    typedef struct packed {
        logic             mode;
        logic [SwW-1:0]   switch_id;
        logic [MacW-1:0]  src_mac;
        logic [MacW-1:0]  dst_mac;
        logic [PortW-1:0] in_port;
        logic             is_ethernet;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [PortW-1:0] egress_port;
        logic             table_full;
    } out_item_t;

    // Command broadcast by the controller to every cell in the same cycle
    typedef struct packed {
        logic              learn;     // compare source key, claim on win
        logic              sweep;     // age test on every cell
        logic [SwW-1:0]    sw;
        logic [MacW-1:0]   src;
        logic [MacW-1:0]   dst;
        logic [PortW-1:0]  port;
        logic [StampW-1:0] now;
        logic [CfgW-1:0]   max_age;
    } cell_cmd_t;

    // Chain signals handed from one cell to the next
    typedef struct packed {
        logic             free_seen;  // a lower cell is free
        logic             src_hit;    // source key found in a lower cell
        logic             dst_hit;    // destination found in a lower cell
        logic [PortW-1:0] dst_port;
    } chain_t;
endpackage
`default_nettype wire

// File: src/l2lt_cell.sv
// One table entry with key compare, claim and age logic.
`default_nettype none
module l2lt_cell
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire l2lt_pkg::cell_cmd_t cmd,
    input  wire logic              any_src_hit,
    input  wire l2lt_pkg::chain_t  chain_in,
    output l2lt_pkg::chain_t       chain_out
);
    import l2lt_pkg::*;

    logic              valid_reg, valid_next;
    logic [SwW-1:0]    sw_reg;
    logic [MacW-1:0]   mac_reg;
    logic [PortW-1:0]  port_reg;
    logic [StampW-1:0] stamp_reg;
    logic              key_src, key_dst, claim, refresh;
    logic [StampW-1:0] age;

    assign key_src = valid_reg && sw_reg == cmd.sw && mac_reg == cmd.src;
    assign key_dst = valid_reg && sw_reg == cmd.sw && mac_reg == cmd.dst;
    assign claim   = cmd.learn && !any_src_hit && !valid_reg && !chain_in.free_seen;
    assign refresh = cmd.learn && key_src;
    assign age     = cmd.now - stamp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (claim)
        begin
            valid_next = 1'b1;
        end
        else if (cmd.sweep && valid_reg && age > {{(StampW-CfgW){1'b0}}, cmd.max_age})
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            sw_reg  <= cmd.sw;
            mac_reg <= cmd.src;
        end
        if (claim || refresh)
        begin
            port_reg  <= cmd.port;
            stamp_reg <= cmd.now;
        end
    end

    always_comb
    begin
        chain_out.free_seen = chain_in.free_seen || !valid_reg;
        chain_out.src_hit   = chain_in.src_hit || key_src;
        chain_out.dst_hit   = chain_in.dst_hit || key_dst;
        chain_out.dst_port  = chain_in.dst_hit ? chain_in.dst_port : port_reg;
    end
endmodule
`default_nettype wire

// File: src/l2_learning_table_with_aging.sv
// Top level: controller, configuration and the chain of table cells.
// A learned packet passes the cell chain in a learn state that refreshes or
// claims the lowest free cell, then in a lookup state for the destination.
// On a tick, any sweep ages all cells in parallel as the tick is taken. The
// result sits in an output register and the input is held off until it has
// gone: a tick or an ignored packet goes from idle straight to the output
// state, a learned packet through learn and lookup first; the result waits
// for out_ready. The valid bits clear at reset; no clearing pass.
`default_nettype none
module l2_learning_table_with_aging #(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire l2lt_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output l2lt_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import l2lt_pkg::*;

    typedef enum logic [1:0] { ST_IDLE, ST_LEARN, ST_LOOKUP, ST_OUT } state_t;

    state_t            state_reg;
    in_item_t          item_reg;
    out_item_t         res_reg;
    logic [CfgW-1:0]   max_age_reg, aging_reg, count_reg;
    logic [StampW-1:0] now_reg;
    logic              full_reg;
    cell_cmd_t         cmd;
    chain_t            chain [TABLE_ENTRIES+1];
    logic              do_sweep, take;

    assign chain[0] = '0;
    generate
        for (genvar g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            l2lt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd),
                .any_src_hit(chain[TABLE_ENTRIES].src_hit),
                .chain_in(chain[g]), .chain_out(chain[g+1])
            );
        end
    endgenerate

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign out_data  = res_reg;
    assign cfg_ready = 1'b1;
    assign take      = in_valid && in_ready;
    assign do_sweep  = take && in_data.mode == MODE_TICK && count_reg <= 16'd1;

    always_comb
    begin
        cmd.learn   = state_reg == ST_LEARN;
        cmd.sweep   = do_sweep;
        cmd.sw      = item_reg.switch_id;
        cmd.src     = item_reg.src_mac;
        cmd.dst     = item_reg.dst_mac;
        cmd.port    = item_reg.in_port;
        // the tick's increment is visible to the sweep in the same cycle
        cmd.now     = do_sweep ? now_reg + 32'd1 : now_reg;
        cmd.max_age = max_age_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_age_reg <= MaxAgeReset;
            aging_reg   <= AgingIntReset;
            count_reg   <= AgingIntReset;
            now_reg     <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_AGE:   max_age_reg <= cfg_data;
                    REG_AGING_INT: aging_reg   <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (in_data.mode == MODE_TICK)
                        begin
                            now_reg   <= now_reg + 32'd1;
                            count_reg <= (count_reg <= 16'd1) ? aging_reg
                                                              : count_reg - 16'd1;
                            state_reg <= ST_OUT;
                        end
                        else if (in_data.is_ethernet && in_data.in_port != '0)
                        begin
                            state_reg <= ST_LEARN;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_LEARN:
                begin
                    full_reg  <= !chain[TABLE_ENTRIES].src_hit &&
                                 !chain[TABLE_ENTRIES].free_seen;
                    state_reg <= ST_LOOKUP;
                end
                ST_LOOKUP: state_reg <= ST_OUT;
                ST_OUT:    if (out_ready) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
            res_reg  <= '{action: ACT_NONE, egress_port: '0, table_full: 1'b0};
        end
        else if (state_reg == ST_LOOKUP)
        begin
            res_reg.table_full <= full_reg;
            if (chain[TABLE_ENTRIES].dst_hit)
            begin
                res_reg.action      <= ACT_FORWARD;
                res_reg.egress_port <= chain[TABLE_ENTRIES].dst_port;
            end
            else
            begin
                res_reg.action      <= ACT_FLOOD;
                res_reg.egress_port <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// File: src/l2lt_checker.sv
// Port-level checker for the learning table and its bind.
`default_nettype none
module l2lt_checker
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire l2lt_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire l2lt_pkg::out_item_t out_data
);
    import l2lt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_tick_none: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.mode == MODE_TICK |=> out_valid &&
        out_data.action == ACT_NONE && !out_data.table_full)
        else $error("tick gave an action");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action != ACT_FORWARD |-> out_data.egress_port == '0)
        else $error("port without forward");
endmodule

bind l2_learning_table_with_aging l2lt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);
`default_nettype wire
